// File: hw/rtl/skl_pkg.sv
// Package for the sorted key list: opcodes, status codes and cell control.
`default_nettype none

package skl_pkg;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_REMOVED   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   localparam int KEY_W    = 32;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic capture;    // latch compare flags against the broadcast key
      logic do_insert;  // open a slot at the boundary and shift up
      logic do_remove;  // close the slot at the boundary and shift down
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: hw/rtl/skl_if.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface skl_req_if;
   logic                 valid;
   logic                 ready;
   skl_pkg::op_type      op;
   logic signed [31:0]   key;

   modport source (output valid, output op, output key, input ready);
   modport sink   (input valid, input op, input key, output ready);
endinterface

interface skl_rsp_if;
   logic                 valid;
   logic                 ready;
   skl_pkg::status_type  status;
   logic [3:0]           position;
   logic [4:0]           count;

   modport source (output valid, output status, output position, output count,
                   input ready);
   modport sink   (input valid, input status, input position, input count,
                   output ready);
endinterface

`default_nettype wire

// File: hw/rtl/skl_cell.sv
// One storage cell of the sorted chain: holds a key and its compare flags.
`default_nettype none

module skl_cell (
   input  wire                          clock,
   input  skl_pkg::cell_ctrl_type       ctrl,
   input  wire logic signed [31:0]      bcast_key,
   input  wire logic                    valid,
   input  wire logic signed [31:0]      prev_key,
   input  wire logic                    prev_less,
   input  wire logic signed [31:0]      next_key,
   output logic signed [31:0]           key_out,
   output logic                         less_out,
   output logic                         eq_out
);
   import skl_pkg::*;

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic                    less_ff, less_in;
   logic                    eq_ff, eq_in;

   always_comb begin
      less_in = less_ff;
      eq_in   = eq_ff;
      if (ctrl.capture) begin
         less_in = valid && (key_ff < bcast_key);
         eq_in   = valid && (key_ff == bcast_key);
      end
   end

   always_comb begin
      key_in = key_ff;
      if (ctrl.do_insert) begin
         // cells past the boundary take their lower neighbor's key
         if (!prev_less) begin
            key_in = prev_key;
         end else if (!less_ff) begin
            key_in = bcast_key;
         end
      end else if (ctrl.do_remove) begin
         if (!less_ff) begin
            key_in = next_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      less_ff <= less_in;
      eq_ff   <= eq_in;
   end

   assign key_out  = key_ff;
   assign less_out = less_ff;
   assign eq_out   = eq_ff;

endmodule

`default_nettype wire

// File: hw/rtl/sorted_key_list_top.sv
// Sorted key list: controller and chain of key cells.
`default_nettype none

// Keeps up to CAPACITY signed keys in ascending order in a chain of cells.
// Each request inserts a key in front of the first stored key that is not
// smaller, or removes the first stored key that equals it; each request
// gives one response with status, position and the count afterwards. A
// request passes through the states idle, in which it is taken, compare, in
// which every cell compares its key with the request key in parallel, and
// apply, in which the boundary cell is found and the chain shifts by one place.
// The apply state waits while an earlier response is still held, and no new
// request is accepted until the block is back in idle.
// Position and count are reported modulo 16 and 32.
module sorted_key_list_top #(
   parameter int CAPACITY = 16
) (
   input  wire         clock,
   input  wire         reset,
   skl_req_if.sink     req_chan,
   skl_rsp_if.source   rsp_chan
);
   import skl_pkg::*;

   localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_APPLY
   } state_type;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             status_ff, status_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   cell_ctrl_type          ctrl;
   logic signed [KEY_W-1:0] cell_key [CAPACITY];
   logic [CAPACITY-1:0]    cell_less;
   logic [CAPACITY-1:0]    cell_eq;
   logic [CAPACITY-1:0]    cell_valid;
   logic [CAPACITY-1:0]    boundary;
   logic [PW-1:0]          bound_pos;
   logic                   found;
   logic                   full;
   logic                   accept;
   logic                   apply_fire;
   logic                   ins_go;
   logic                   rem_go;

   assign accept     = req_chan.valid && (state_ff == S_IDLE);
   assign apply_fire = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_chan.ready);
   assign full       = (count_ff >= CW'(CAPACITY));

   // boundary is the first cell whose key is not below the request key
   always_comb begin
      boundary  = '0;
      bound_pos = '0;
      found     = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         cell_valid[i] = (CW'(i) < count_ff);
         boundary[i]   = !cell_less[i] && ((i == 0) || cell_less[(i == 0) ? 0 : i - 1]);
         if (boundary[i]) begin
            bound_pos = bound_pos | PW'(i);
         end
         if (boundary[i] && cell_eq[i]) begin
            found = 1'b1;
         end
      end
   end

   assign ins_go = apply_fire && (op_ff == OP_INSERT) && !full;
   assign rem_go = apply_fire && (op_ff == OP_REMOVE) && found;

   assign ctrl.capture   = (state_ff == S_CMP);
   assign ctrl.do_insert = ins_go;
   assign ctrl.do_remove = rem_go;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      skl_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .bcast_key (key_ff),
         .valid     (cell_valid[g]),
         .prev_key  (cell_key[(g == 0) ? 0 : g - 1]),
         .prev_less ((g == 0) ? 1'b1 : cell_less[(g == 0) ? 0 : g - 1]),
         .next_key  (cell_key[(g == CAPACITY - 1) ? g : g + 1]),
         .key_out   (cell_key[g]),
         .less_out  (cell_less[g]),
         .eq_out    (cell_eq[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_chan.op;
               key_in   = req_chan.key;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (apply_fire) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               pos_in       = '0;
               if (op_ff == OP_INSERT) begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     status_in = ST_INSERTED;
                     pos_in    = POS_W'(bound_pos);
                     count_in  = count_ff + CW'(1);
                  end
               end else begin
                  if (found) begin
                     status_in = ST_REMOVED;
                     pos_in    = POS_W'(bound_pos);
                     count_in  = count_ff - CW'(1);
                  end else begin
                     status_in = ST_NOT_FOUND;
                  end
               end
               rsp_count_in = COUNT_W'(count_in);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      status_ff    <= status_in;
      pos_ff       <= pos_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = status_ff;
   assign rsp_chan.position = pos_ff;
   assign rsp_chan.count    = rsp_count_ff;

endmodule

`default_nettype wire

// File: test/tb_sorted_key_list_top.sv
// Testbench for sorted_key_list_top: directed table, random insert/remove traffic, scoreboard.
module tb_sorted_key_list_top;
   timeunit 1ns;
   timeprecision 1ps;

   import skl_pkg::*;

   localparam int CAPACITY = 16;
   localparam int RANDOM_WORDS = 550;
   localparam int MAX_GAP = 4;
   localparam int IDLE_PCT = 22;
   localparam int TAIL_CYCLES = 10;
   localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

   typedef struct {
      status_type  status;
      logic [3:0]  position;
      logic [4:0]  count;
   } rsp_word_type;

   typedef struct {
      op_type              op;
      logic signed [31:0]  key;
      bit                  fixed;
      rsp_word_type        want;
   } dir_row_type;

   logic clock;
   logic reset;

   skl_req_if req_chan ();
   skl_rsp_if rsp_chan ();

   sorted_key_list_top #(.CAPACITY(CAPACITY)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // mirror of the list contents, ascending, newest first among equal keys
   logic signed [31:0] list_keys [CAPACITY];
   int                 list_len;

   rsp_word_type  pending_rsp [$];
   dir_row_type   dir_table [$];
   int            error_count;
   bit            quiet;
   bit            cur_fixed;
   rsp_word_type  cur_want;
   int            n_insert, n_full, n_remove, n_miss;

   function automatic rsp_word_type apply_list_op(op_type op, logic signed [31:0] key);
      rsp_word_type r;
      int slot;
      int i;
      r.position = '0;
      slot = 0;
      while (slot < list_len && list_keys[slot] < key) slot++;
      if (op == OP_INSERT) begin
         if (list_len >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            for (i = list_len; i > slot; i--) list_keys[i] = list_keys[i-1];
            list_keys[slot] = key;
            list_len++;
            r.status = ST_INSERTED;
            r.position = 4'(slot);
         end
      end else if (slot < list_len && list_keys[slot] == key) begin
         for (i = slot; i < list_len - 1; i++) list_keys[i] = list_keys[i+1];
         list_len--;
         r.status = ST_REMOVED;
         r.position = 4'(slot);
      end else begin
         r.status = ST_NOT_FOUND;
      end
      r.count = 5'(list_len);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   task automatic add_row(input op_type op, input logic signed [31:0] key, input bit fixed,
                          input status_type st, input int pos, input int cnt);
      dir_row_type row;
      row.op = op;
      row.key = key;
      row.fixed = fixed;
      row.want.status = st;
      row.want.position = 4'(pos);
      row.want.count = 5'(cnt);
      dir_table.push_back(row);
   endtask

   // Present one word and hold it until the block takes it.
   task automatic send_word(input op_type op, input logic signed [31:0] key);
      int gap;
      gap = (!quiet && $urandom_range(99) < IDLE_PCT) ? $urandom_range(MAX_GAP, 1) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.key <= key;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Hold off the sender until every outstanding response has come back.
   task automatic drain_responses;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // Favor keys that hit the list: small values, stored keys and the extremes.
   function automatic logic signed [31:0] pick_key();
      int sel;
      sel = $urandom_range(99);
      if (sel < 35) return 32'($signed($urandom_range(8)) - 4);
      if (sel < 60 && list_len > 0) return list_keys[$urandom_range(list_len - 1)];
      if (sel < 70) begin
         case ($urandom_range(3))
            0: return KEY_MAX;
            1: return KEY_MIN;
            2: return KEY_MAX - 1;
            default: return KEY_MIN + 1;
         endcase
      end
      return $urandom;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end

   // receiver: stall at random except during the quiet stretch
   initial rsp_chan.ready = 1'b0;
   always @(negedge clock) begin
      rsp_chan.ready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
   end

   // scoreboard: log accepted requests first, then check the response word
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      rsp_word_type calc;
      if (!reset && req_chan.valid && req_chan.ready) begin
         calc = apply_list_op(req_chan.op, req_chan.key);
         case (calc.status)
            ST_INSERTED:  n_insert++;
            ST_FULL:      begin n_insert++; n_full++; end
            ST_REMOVED:   n_remove++;
            default:      begin n_remove++; n_miss++; end
         endcase
         pending_rsp.push_back(cur_fixed ? cur_want : calc);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.status = rsp_chan.status;
         got.position = rsp_chan.position;
         got.count = rsp_chan.count;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response status", got.status, -1);
         end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
            if (got.position !== want.position)
               report_mismatch("position", got.position, want.position);
            if (got.count !== want.count)
               report_mismatch("count", got.count, want.count);
         end
      end
   end

   initial begin
      op_type op;
      int ins_pct;
      error_count = 0;
      n_insert = 0;
      n_full = 0;
      n_remove = 0;
      n_miss = 0;
      list_len = 0;
      quiet = 1'b0;
      cur_fixed = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.op = OP_INSERT;
      req_chan.key = '0;

      add_row(OP_REMOVE, 0,       1, ST_NOT_FOUND, 0, 0);
      add_row(OP_INSERT, KEY_MAX, 1, ST_INSERTED,  0, 1);
      add_row(OP_INSERT, KEY_MIN, 1, ST_INSERTED,  0, 2);
      add_row(OP_INSERT, 0,       1, ST_INSERTED,  1, 3);
      add_row(OP_INSERT, 0,       1, ST_INSERTED,  1, 4);
      add_row(OP_REMOVE, 0,       1, ST_REMOVED,   1, 3);
      add_row(OP_REMOVE, 5,       1, ST_NOT_FOUND, 0, 3);
      add_row(OP_INSERT, -1,           0, ST_INSERTED, 0, 0);
      add_row(OP_INSERT, 1,            0, ST_INSERTED, 0, 0);
      add_row(OP_INSERT, 7,            0, ST_INSERTED, 0, 0);
      add_row(OP_INSERT, -7,           0, ST_INSERTED, 0, 0);
      add_row(OP_INSERT, 100,          0, ST_INSERTED, 0, 0);
      add_row(OP_INSERT, -100,         0, ST_INSERTED, 0, 0);
      add_row(OP_INSERT, 32'h4000_0000, 0, ST_INSERTED, 0, 0);
      add_row(OP_INSERT, 32'hc000_0000, 0, ST_INSERTED, 0, 0);
      add_row(OP_INSERT, 3,            0, ST_INSERTED, 0, 0);
      add_row(OP_INSERT, -3,           0, ST_INSERTED, 0, 0);
      add_row(OP_INSERT, KEY_MIN,      0, ST_INSERTED, 0, 0);
      add_row(OP_INSERT, 1,            0, ST_INSERTED, 0, 0);
      add_row(OP_INSERT, 0,            0, ST_INSERTED, 0, 0);
      add_row(OP_INSERT, 9,       1, ST_FULL,      0, 16);
      add_row(OP_REMOVE, KEY_MAX, 1, ST_REMOVED,  15, 15);
      add_row(OP_INSERT, KEY_MAX, 1, ST_INSERTED, 15, 16);
      add_row(OP_REMOVE, KEY_MIN, 1, ST_REMOVED,   0, 15);
      add_row(OP_REMOVE, 12345,   1, ST_NOT_FOUND, 0, 15);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // update after the scoreboard has logged the word just taken
      foreach (dir_table[i]) begin
         cur_fixed <= dir_table[i].fixed;
         cur_want <= dir_table[i].want;
         send_word(dir_table[i].op, dir_table[i].key);
      end
      cur_fixed <= 1'b0;
      drain_responses();

      ins_pct = 50;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // swing between filling and emptying phases so both ends get hit
         if (n % 40 == 0) ins_pct = $urandom_range(85, 15);
         if (n == 275) drain_responses();
         quiet = (n >= 120 && n < 300);
         op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
         send_word(op, pick_key());
      end
      quiet = 1'b0;
      drain_responses();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_rsp.size() != 0)
         report_mismatch("responses still outstanding", 0, pending_rsp.size());

      $display("Covered %0d inserts (%0d refused on a full list) and %0d removes (%0d misses)",
               n_insert, n_full, n_remove, n_miss);
      $display("with random stalls on both channels and one stall-free stretch; %0d mismatches",
               error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/skl_pkg.sv
hw/rtl/skl_if.sv
hw/rtl/skl_cell.sv
hw/rtl/sorted_key_list_top.sv
test/tb_sorted_key_list_top.sv
